[hdl/qet_pkg.sv]
// Package for the quoted, escaped tokenizer.
// Holds the scan state type, the queue entry and status types, byte constants
// and the escape translation. It depends on nothing.
package qet_pkg;

   // Scan state of the front part.
   typedef enum logic [1:0] {
      MODE_SKIP   = 2'd0,
      MODE_PLAIN  = 2'd1,
      MODE_QUOTED = 2'd2
   } qet_mode_type;

   // Register indexes on the configuration port.
   typedef enum logic [2:0] {
      REG_DELIM_COUNT = 3'd0,
      REG_DELIM_A     = 3'd1,
      REG_DELIM_B     = 3'd2,
      REG_DELIM_C     = 3'd3,
      REG_DELIM_D     = 3'd4
   } qet_reg_type;

   localparam int unsigned CSR_ADDR_W = 5;

   // Byte codes.
   localparam logic [7:0] CHAR_SPACE     = 8'd32;
   localparam logic [7:0] CHAR_TAB       = 8'd9;
   localparam logic [7:0] CHAR_QUOTE     = 8'd34;
   localparam logic [7:0] CHAR_BACKSLASH = 8'd92;
   localparam logic [7:0] CHAR_LOWER_N   = 8'd110;
   localparam logic [7:0] CHAR_LOWER_R   = 8'd114;
   localparam logic [7:0] CHAR_LOWER_B   = 8'd98;
   localparam logic [7:0] CHAR_LOWER_T   = 8'd116;
   localparam logic [7:0] CHAR_LF        = 8'd10;
   localparam logic [7:0] CHAR_CR        = 8'd13;
   localparam logic [7:0] CHAR_BEL       = 8'd7;
   localparam logic [7:0] CHAR_HT        = 8'd9;

   localparam logic [2:0] DELIM_COUNT_RESET = 3'd1;
   localparam logic [7:0] DELIM_A_RESET     = 8'd44;

   // One queued job: a beat, and whether an end beat follows it.
   typedef struct packed {
      logic [7:0] token_byte;
      logic       token_end;
      logic       end_follows;
   } qet_entry_type;

   // Queue status seen by the front and back parts.
   typedef struct packed {
      logic full;
      logic empty;
   } qet_queue_status_type;

   // Translation of the byte after a backslash.
   function automatic logic [7:0] unescape(input logic [7:0] b);
      logic [7:0] r;
      case (b)
         CHAR_LOWER_N: r = CHAR_LF;
         CHAR_LOWER_R: r = CHAR_CR;
         CHAR_LOWER_B: r = CHAR_BEL;
         CHAR_LOWER_T: r = CHAR_HT;
         default:      r = b;
      endcase
      return r;
   endfunction

endpackage

[hdl/qet_queue.sv]
// Short queue of jobs between the front and back parts of the tokenizer.
// Register-based first-in first-out store; depends on qet_pkg.
module qet_queue
   import qet_pkg::*;
#(
   parameter int unsigned DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  qet_entry_type        push_entry,
   input  logic                 pop,
   output qet_entry_type        head_entry,
   output qet_queue_status_type status
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   qet_entry_type    mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // Pointer and fill count updates, with wrap at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head_entry   = mem_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

[hdl/qet_front.sv]
// Front part of the tokenizer: accepts line beats, tracks the scan state and
// queues the token beats that each one causes. Depends on qet_pkg.
module qet_front
   import qet_pkg::*;
#(
   parameter int unsigned MAX_DELIMITERS = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,
   input  logic                      req_tlast,
   input  logic [7:0]                delim_bytes [MAX_DELIMITERS],
   input  logic [MAX_DELIMITERS-1:0] delim_active,
   input  qet_queue_status_type      queue_status,
   output logic                      push,
   output qet_entry_type             push_entry
);

   qet_mode_type mode_ff, mode_in;
   logic         esc_ff, esc_in;

   logic accept;
   logic is_space;
   logic is_quote;
   logic is_bslash;
   logic byte_is_delim;
   logic bslash_is_delim;
   logic plain_path;
   logic esc_now;

   assign req_tready = !queue_status.full;
   assign accept     = req_tvalid && req_tready;

   // Byte classification.
   assign is_space  = (req_tdata == CHAR_SPACE) || (req_tdata == CHAR_TAB);
   assign is_quote  = (req_tdata == CHAR_QUOTE);
   assign is_bslash = (req_tdata == CHAR_BACKSLASH);

   // Delimiter matching against the active registers.
   always_comb begin
      byte_is_delim   = 1'b0;
      bslash_is_delim = 1'b0;
      for (int i = 0; i < MAX_DELIMITERS; i++) begin
         if (delim_active[i] && (delim_bytes[i] == req_tdata)) begin
            byte_is_delim = 1'b1;
         end
         if (delim_active[i] && (delim_bytes[i] == CHAR_BACKSLASH)) begin
            bslash_is_delim = 1'b1;
         end
      end
   end

   // A non-blank byte while skipping is handled as an unquoted token byte.
   assign plain_path = (mode_ff == MODE_PLAIN) || ((mode_ff == MODE_SKIP) && !is_space);
   assign esc_now    = (mode_ff == MODE_PLAIN) && esc_ff;

   // Next scan state.
   always_comb begin
      mode_in = mode_ff;
      esc_in  = esc_ff;
      if (accept) begin
         if (req_tlast) begin
            mode_in = MODE_SKIP;
            esc_in  = 1'b0;
         end else begin
            case (mode_ff)
               MODE_QUOTED: begin
                  if (is_quote) begin
                     mode_in = MODE_PLAIN;
                  end
               end
               MODE_SKIP, MODE_PLAIN: begin
                  if (plain_path) begin
                     mode_in = MODE_PLAIN;
                     esc_in  = 1'b0;
                     if (!esc_now) begin
                        if (is_quote) begin
                           mode_in = MODE_QUOTED;
                        end else if (is_bslash) begin
                           esc_in = 1'b1;
                        end else if (byte_is_delim) begin
                           mode_in = MODE_SKIP;
                        end
                     end
                  end
               end
               default: begin
                  mode_in = MODE_SKIP;
                  esc_in  = 1'b0;
               end
            endcase
         end
      end
   end

   // Queued beats for the accepted item.
   always_comb begin
      push       = 1'b0;
      push_entry = '0;
      if (accept) begin
         if (req_tlast) begin
            if (mode_ff != MODE_SKIP) begin
               push = 1'b1;
               if (esc_ff && !bslash_is_delim) begin
                  push_entry.token_byte  = CHAR_BACKSLASH;
                  push_entry.end_follows = 1'b1;
               end else begin
                  push_entry.token_end = 1'b1;
               end
            end
         end else if (mode_ff == MODE_QUOTED) begin
            if (!is_quote) begin
               push                  = 1'b1;
               push_entry.token_byte = req_tdata;
            end
         end else if (plain_path) begin
            if (esc_now) begin
               push                  = 1'b1;
               push_entry.token_byte = unescape(req_tdata);
            end else if (byte_is_delim && !is_quote && !is_bslash) begin
               push                 = 1'b1;
               push_entry.token_end = 1'b1;
            end else if (!is_quote && !is_bslash) begin
               push                  = 1'b1;
               push_entry.token_byte = req_tdata;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_SKIP;
         esc_ff  <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         esc_ff  <= esc_in;
      end
   end

endmodule

[hdl/qet_back.sv]
// Back part of the tokenizer: takes queued jobs and drives the token beats
// from an output register. Depends on qet_pkg.
module qet_back
   import qet_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  qet_entry_type        head_entry,
   input  qet_queue_status_type queue_status,
   output logic                 pop,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,   // token_byte
   output logic                 rsp_tlast    // token_end
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       end_ff, end_in;
   logic       extra_ff, extra_in;
   logic       take;

   // The output register is free when empty or when its beat leaves now.
   assign take = !valid_ff || rsp_tready;
   assign pop  = take && !extra_ff && !queue_status.empty;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      end_in   = end_ff;
      extra_in = extra_ff;
      if (take) begin
         if (extra_ff) begin
            // Closing beat after a dangling backslash at line end.
            valid_in = 1'b1;
            byte_in  = '0;
            end_in   = 1'b1;
            extra_in = 1'b0;
         end else if (!queue_status.empty) begin
            valid_in = 1'b1;
            byte_in  = head_entry.token_byte;
            end_in   = head_entry.token_end;
            extra_in = head_entry.end_follows;
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         extra_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         extra_ff <= extra_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      end_ff  <= end_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tlast  = end_ff;

endmodule

[hdl/quoted_escaped_tokenizer.sv]
// Quoted, escaped tokenizer: top level with the register port.
// Instantiates qet_front, qet_queue and qet_back; depends on qet_pkg.
//
// Line bytes enter on the req_ stream, one beat per byte; a beat with
// req_tlast high ends the line and its data is ignored. Token bytes leave on
// the rsp_ stream; a beat with rsp_tlast high (data zero) ends a token.
// Blanks before a token are dropped, a double quote switches quoting, and a
// backslash outside quotes escapes the next byte. Up to four delimiter bytes
// are set on the csr_ port (count at 0x0, bytes at 0x4 to 0x10).
// Throughput: one input beat per cycle while the queue is not full. Each
// input beat gives at most one output beat, except a line end with a
// backslash pending, which gives two. The front classifies an accepted beat
// in the same cycle and writes its job into the queue at the accepting edge;
// the output register loads it from the queue head once that register is free.
// The four-entry queue between front and back absorbs receiver stalls;
// req_tready falls only when that queue is full.
// Reset clears the scan state, the queue and the output register, and sets
// the delimiter count to one with comma as the first delimiter.
module quoted_escaped_tokenizer
   import qet_pkg::*;
#(
   parameter int unsigned MAX_DELIMITERS = 4,
   parameter int unsigned QUEUE_DEPTH    = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // line_byte
   input  logic                  req_tlast,   // line_end
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,   // token_byte
   output logic                  rsp_tlast,   // token_end
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic [2:0]                count_ff;
   logic [7:0]                delim_ff [MAX_DELIMITERS];
   logic [MAX_DELIMITERS-1:0] delim_active;
   logic [2:0]                reg_index;
   logic                      csr_write;

   logic                      queue_push;
   logic                      queue_pop;
   qet_entry_type             push_entry;
   qet_entry_type             head_entry;
   qet_queue_status_type      queue_status;

   // Register port decode.
   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Delimiter count register.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= DELIM_COUNT_RESET;
      end else if (csr_write && (reg_index == REG_DELIM_COUNT)) begin
         count_ff <= csr_pwdata[2:0];
      end
   end

   // Delimiter byte registers; writes to an absent one are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_DELIMITERS; i++) begin
            delim_ff[i] <= (i == 0) ? DELIM_A_RESET : 8'd0;
         end
      end else if (csr_write) begin
         for (int i = 0; i < MAX_DELIMITERS; i++) begin
            if (reg_index == 3'(i + 1)) begin
               delim_ff[i] <= csr_pwdata[7:0];
            end
         end
      end
   end

   // A count above the register count simply enables them all.
   always_comb begin
      for (int i = 0; i < MAX_DELIMITERS; i++) begin
         delim_active[i] = (count_ff > 3'(i));
      end
   end

   // Register read back.
   always_comb begin
      csr_prdata = '0;
      case (reg_index)
         REG_DELIM_COUNT: csr_prdata = {29'd0, count_ff};
         default: begin
            for (int i = 0; i < MAX_DELIMITERS; i++) begin
               if (reg_index == 3'(i + 1)) begin
                  csr_prdata = {24'd0, delim_ff[i]};
               end
            end
         end
      endcase
   end

   qet_front #(
      .MAX_DELIMITERS(MAX_DELIMITERS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .delim_bytes (delim_ff),
      .delim_active(delim_active),
      .queue_status(queue_status),
      .push        (queue_push),
      .push_entry  (push_entry)
   );

   qet_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_entry(push_entry),
      .pop       (queue_pop),
      .head_entry(head_entry),
      .status    (queue_status)
   );

   qet_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_entry  (head_entry),
      .queue_status(queue_status),
      .pop         (queue_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

   // The queue is never written while full nor read while empty.
   assert property (@(posedge clock) disable iff (reset)
      !(queue_push && queue_status.full) && !(queue_pop && queue_status.empty))
      else $error("tokenizer queue overrun or underrun");

   // No output beat at the first edge after reset is released.
   assert property (@(posedge clock) $fell(reset) |-> !rsp_tvalid)
      else $error("output beat present after reset");

   // A count register write lands with the written value.
   assert property (@(posedge clock) disable iff (reset)
      (csr_write && (reg_index == REG_DELIM_COUNT)) |=> (count_ff == $past(csr_pwdata[2:0])))
      else $error("delimiter count write lost");

   // An end-of-token beat carries no byte.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tdata == 8'd0))
      else $error("end-of-token beat carries data");

endmodule

[verif/tb_quoted_escaped_tokenizer.sv]
`timescale 1ns / 100ps
// Self-checking bench for quoted_escaped_tokenizer: line beats in, token beats out.
// A behavioural predictor tracks scan state and delimiter registers; depends on qet_pkg.
module tb_quoted_escaped_tokenizer;
   import qet_pkg::*;

   localparam int unsigned DELIM_SLOTS   = 4;
   localparam int          SETTLE_CYCLES = 8;
   localparam int          LIMIT_CYCLES  = 500000;

   typedef struct packed {
      logic [7:0] line_byte;
      logic       line_end;
   } line_beat_t;

   typedef struct packed {
      logic [7:0] token_byte;
      logic       token_end;
   } token_beat_t;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata   = 8'd0;   // line_byte
   logic                  req_tlast   = 1'b0;   // line_end
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [7:0]            rsp_tdata;            // token_byte
   logic                  rsp_tlast;            // token_end
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [31:0]           csr_pwdata  = 32'd0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   // Predictor state: scan mode, pending escape and a copy of the registers.
   qet_mode_type scan_state    = MODE_SKIP;
   logic         escape_armed  = 1'b0;
   logic [2:0]   delim_count_cfg = DELIM_COUNT_RESET;
   logic [7:0]   delim_bytes [DELIM_SLOTS] = '{DELIM_A_RESET, 8'd0, 8'd0, 8'd0};

   line_beat_t  line_beats_pending [$];
   token_beat_t tokens_due [$];
   int          line_beats_queued   = 0;
   int          line_beats_accepted = 0;
   int          error_count         = 0;
   int          cycle_count         = 0;
   int          rx_hold_left        = 0;
   bit          gaps_on             = 1'b1;
   bit          stalls_on           = 1'b1;

   quoted_escaped_tokenizer #(
      .MAX_DELIMITERS(DELIM_SLOTS)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Clock with a 10 ns period.
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Idle length: mostly none, sometimes short, now and then a long pause.
   function automatic int pick_gap(bit enabled);
      int r;
      if (!enabled) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic bit is_delimiter(logic [7:0] b);
      int n;
      n = (delim_count_cfg > DELIM_SLOTS) ? DELIM_SLOTS : delim_count_cfg;
      for (int i = 0; i < n; i++)
         if (delim_bytes[i] == b) return 1'b1;
      return 1'b0;
   endfunction

   function automatic logic [7:0] escaped_value(logic [7:0] b);
      case (b)
         CHAR_LOWER_N: return CHAR_LF;
         CHAR_LOWER_R: return CHAR_CR;
         CHAR_LOWER_B: return CHAR_BEL;
         CHAR_LOWER_T: return CHAR_HT;
         default:      return b;
      endcase
   endfunction

   function automatic void expect_token(logic [7:0] b, logic last);
      tokens_due.push_back('{token_byte: b, token_end: last});
   endfunction

   // Advances the scan state by one accepted line beat and queues the token beats it gives.
   function automatic void predict_line_beat(logic [7:0] b, logic last);
      if (last) begin
         // The line end closes an open token; a dangling backslash is kept unless it delimits.
         if (scan_state != MODE_SKIP) begin
            if (escape_armed && !is_delimiter(CHAR_BACKSLASH))
               expect_token(CHAR_BACKSLASH, 1'b0);
            expect_token(8'd0, 1'b1);
         end
         scan_state   = MODE_SKIP;
         escape_armed = 1'b0;
         return;
      end
      if (scan_state == MODE_SKIP) begin
         if (b == CHAR_SPACE || b == CHAR_TAB) return;
         scan_state   = MODE_PLAIN;
         escape_armed = 1'b0;
      end
      if (scan_state == MODE_QUOTED) begin
         if (b == CHAR_QUOTE)
            scan_state = MODE_PLAIN;
         else
            expect_token(b, 1'b0);
      end else if (escape_armed) begin
         escape_armed = 1'b0;
         expect_token(escaped_value(b), 1'b0);
      end else if (b == CHAR_QUOTE) begin
         scan_state = MODE_QUOTED;
      end else if (b == CHAR_BACKSLASH) begin
         escape_armed = 1'b1;
      end else if (is_delimiter(b)) begin
         expect_token(8'd0, 1'b1);
         scan_state = MODE_SKIP;
      end else begin
         expect_token(b, 1'b0);
      end
   endfunction

   // Line beat driver: offers queued beats, idling at random between them.
   always @(posedge clock) begin : line_driver
      line_beat_t beat;
      int         gap_left;
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_line_beat(req_tdata, req_tlast);
            line_beats_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (line_beats_pending.size() > 0) begin
               beat = line_beats_pending.pop_front();
               req_tvalid <= 1'b1;
               // The byte is ignored on a line end, so it carries noise there.
               req_tdata  <= beat.line_end ? 8'($urandom) : beat.line_byte;
               req_tlast  <= beat.line_end;
               gap_left = pick_gap(gaps_on);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Token beat monitor: checks each beat against the oldest prediction and stalls at random.
   always @(posedge clock) begin : token_monitor
      token_beat_t due;
      int          stall_left;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (tokens_due.size() == 0) begin
               $display("%0t: unexpected token beat, got byte %h end %b",
                        $time, rsp_tdata, rsp_tlast);
               error_count++;
            end else begin
               due = tokens_due.pop_front();
               if (rsp_tdata !== due.token_byte) begin
                  $display("%0t: token_byte expected %h, got %h",
                           $time, due.token_byte, rsp_tdata);
                  error_count++;
               end
               if (rsp_tlast !== due.token_end) begin
                  $display("%0t: token_end expected %b, got %b",
                           $time, due.token_end, rsp_tlast);
                  error_count++;
               end
            end
         end
         if (rx_hold_left > 0) begin
            rx_hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            stall_left = pick_gap(stalls_on);
         end
      end
   end

   function automatic void push_byte(logic [7:0] b);
      line_beats_pending.push_back('{line_byte: b, line_end: 1'b0});
      line_beats_queued++;
   endfunction

   function automatic void push_end();
      line_beats_pending.push_back('{line_byte: 8'd0, line_end: 1'b1});
      line_beats_queued++;
   endfunction

   function automatic void push_text(string s);
      for (int i = 0; i < s.len(); i++)
         push_byte(s[i]);
   endfunction

   function automatic logic [7:0] pick_escape_target();
      case ($urandom_range(0, 7))
         0:       return CHAR_LOWER_N;
         1:       return CHAR_LOWER_R;
         2:       return CHAR_LOWER_B;
         3:       return CHAR_LOWER_T;
         4:       return CHAR_QUOTE;
         5:       return CHAR_BACKSLASH;
         6:       return delim_bytes[$urandom_range(0, DELIM_SLOTS - 1)];
         default: return 8'($urandom);
      endcase
   endfunction

   // A line of tokens with random content: letters, blanks, delimiters, quotes and escapes.
   function automatic void queue_text_line();
      int len;
      int r;
      len = $urandom_range(0, 14);
      for (int i = 0; i < len; i++) begin
         r = $urandom_range(0, 99);
         if (r < 40) begin
            push_byte(8'($urandom_range(97, 122)));
         end else if (r < 50) begin
            push_byte($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
         end else if (r < 64) begin
            push_byte(delim_bytes[$urandom_range(0, DELIM_SLOTS - 1)]);
         end else if (r < 72) begin
            push_byte(CHAR_QUOTE);
         end else if (r < 84) begin
            push_byte(CHAR_BACKSLASH);
            push_byte(pick_escape_target());
         end else if (r < 89) begin
            push_byte(CHAR_BACKSLASH);
         end else begin
            push_byte(8'($urandom));
         end
      end
      push_end();
   endfunction

   // Noise: any byte values, then a line end.
   function automatic void queue_noise_line();
      int len;
      len = $urandom_range(1, 10);
      for (int i = 0; i < len; i++)
         push_byte(8'($urandom));
      push_end();
   endfunction

   function automatic logic [7:0] pick_delimiter();
      if ($urandom_range(0, 1)) return 8'($urandom);
      case ($urandom_range(0, 7))
         0:       return 8'd44;
         1:       return CHAR_SPACE;
         2:       return CHAR_TAB;
         3:       return CHAR_QUOTE;
         4:       return CHAR_BACKSLASH;
         5:       return 8'h00;
         6:       return 8'hFF;
         default: return CHAR_LOWER_N;
      endcase
   endfunction

   task automatic write_reg(logic [2:0] index, logic [31:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      // Only the register bits are kept; writes past the last register are dropped.
      if (index == REG_DELIM_COUNT)
         delim_count_cfg = data[2:0];
      else if (index <= REG_DELIM_D)
         delim_bytes[index - 1] = data[7:0];
   endtask

   task automatic check_reg(logic [2:0] index, logic [31:0] want);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {index, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== want) begin
         $display("%0t: register %0d read expected %h, got %h", $time, index, want, csr_prdata);
         error_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic check_registers();
      check_reg(REG_DELIM_COUNT, {29'd0, delim_count_cfg});
      for (int i = 0; i < DELIM_SLOTS; i++)
         check_reg(3'(int'(REG_DELIM_A) + i), {24'd0, delim_bytes[i]});
   endtask

   // Writes every register with noise above its width, tries an unused address, reads back.
   task automatic set_delimiters(logic [2:0] count, logic [7:0] a, logic [7:0] b,
                                 logic [7:0] c, logic [7:0] d);
      write_reg(REG_DELIM_COUNT, ($urandom & ~32'h7) | count);
      write_reg(REG_DELIM_A, ($urandom & ~32'hFF) | a);
      write_reg(REG_DELIM_B, ($urandom & ~32'hFF) | b);
      write_reg(REG_DELIM_C, ($urandom & ~32'hFF) | c);
      write_reg(REG_DELIM_D, ($urandom & ~32'hFF) | d);
      write_reg(3'($urandom_range(int'(REG_DELIM_D) + 1, 7)), $urandom);
      check_registers();
   endtask

   // Holds the sender until every beat is taken and every token beat has come back.
   task automatic wait_drained();
      while (line_beats_accepted != line_beats_queued || tokens_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(int beats, bit gaps, bit stalls);
      int start;
      gaps_on   = gaps;
      stalls_on = stalls;
      start = line_beats_queued;
      while (line_beats_queued - start < beats) begin
         if ($urandom_range(0, 99) < 85)
            queue_text_line();
         else
            queue_noise_line();
      end
      wait_drained();
   endtask

   // Run limit.
   initial begin : watchdog
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_quoted_escaped_tokenizer failed");
      $finish;
   end

   initial begin : stimulus
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      check_registers();

      // Reset delimiters (comma only): blanks, empty tokens, quoting and escapes.
      push_text(" \ta,,\"x,\"\\n");
      push_end();
      push_end();
      push_text("\\t\\\"\\,\\");
      push_end();
      push_byte(8'hFF);
      push_byte(8'h00);
      push_text(", ");
      push_end();
      push_text("\"q");
      push_end();
      wait_drained();

      // Extreme delimiters: space, zero, backslash and 255.
      set_delimiters(3'd4, CHAR_SPACE, 8'h00, CHAR_BACKSLASH, 8'hFF);
      push_text("a\\");
      push_end();
      push_text("x");
      push_byte(8'h00);
      push_text("y z\\ ");
      push_byte(8'hFF);
      push_text("\\");
      push_end();
      run_phase(100, 1'b1, 1'b1);

      // No delimiters; the receiver holds off long enough for the block to fill up.
      set_delimiters(3'd0, pick_delimiter(), pick_delimiter(), pick_delimiter(),
                     pick_delimiter());
      rx_hold_left = 250;
      run_phase(110, 1'b0, 1'b0);

      // A count above the number of registers acts as all four.
      set_delimiters(3'd7, 8'd59, CHAR_TAB, 8'd58, 8'd124);
      run_phase(100, 1'b1, 1'b0);

      repeat (3) begin
         set_delimiters(3'($urandom_range(0, 7)), pick_delimiter(), pick_delimiter(),
                        pick_delimiter(), pick_delimiter());
         run_phase(110, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end

      wait_drained();
      if (error_count == 0 && tokens_due.size() == 0)
         $display("tb_quoted_escaped_tokenizer passed");
      else
         $display("tb_quoted_escaped_tokenizer failed");
      $finish;
   end

endmodule
